### hdl/nfass_pkg.sv
package nfass_pkg;

	// Table geometry: 256 byte labels plus one epsilon label per state
	localparam int LABELS     = 257;
	localparam int EPS_LABEL  = 256;

	localparam int NUM_STATES_DEF = 32;
	localparam int TOKEN_BITS_DEF = 8;

	// Beat field widths
	localparam int OP_W     = 2;
	localparam int STATE_W  = 5;
	localparam int LABEL_W  = 9;
	localparam int MASK_W   = 32;
	localparam int TOKEN_W  = 8;
	localparam int SYMBOL_W = 8;
	localparam int IN_W     = 64;
	localparam int OUT_W    = 48;

	// Operation codes
	localparam logic [OP_W-1:0] OP_WR_TRANS  = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_ACCEPT = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART   = 2'd2;
	localparam logic [OP_W-1:0] OP_STEP      = 2'd3;

endpackage

### hdl/nfa_symbol_stepper.sv
// NFA symbol stepper: runs a lexer NFA (up to NUM_STATES states) over a byte stream, the
// active states held as one bit vector. Each input beat is a load (transition mask or
// accept token), a restart (epsilon closure of start_state) or a step (one byte); every
// beat returns one output beat with the active set, an empty flag and the smallest
// accept token among active states. The transition table lives in one synchronous RAM
// of NUM_STATES*257 words, one read per cycle. A step gathers the byte targets in one
// pass over the states, then runs epsilon passes (at least one, at most NUM_STATES+1)
// until a pass adds no state, then scans the states for the accept token, loads the
// output register (waiting while the previous result is still not taken) and goes back
// to idle to take the next beat; restart skips the byte pass; loads run only the token
// scan and output. The RAM read port is the limit: one state's word per cycle. After
// reset the block clears the table with s_tready low; configuration writes are taken
// during that time.
module nfa_symbol_stepper
	import nfass_pkg::*;
#(
	parameter int NUM_STATES = NUM_STATES_DEF,
	parameter int TOKEN_BITS = TOKEN_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [STATE_W-1:0]  cfg_data,   // start_state
	input  logic                s_tvalid,
	output logic                s_tready,
	// state_index[4:0], label[13:5], target_mask[45:14], token_valid[46],
	// token[54:47], symbol[62:55], zero pad[63]
	input  logic [IN_W-1:0]     s_tdata,
	input  logic [OP_W-1:0]     s_tuser,    // operation[1:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	// active_set[31:0], set_empty[32], accept_found[33], accept_token[41:34],
	// zero pad[47:42]
	output logic [OUT_W-1:0]    m_tdata
);

	localparam int DEPTH = NUM_STATES * LABELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SB    = $clog2(NUM_STATES);
	localparam int CB    = $clog2(NUM_STATES + 1);
	localparam int NW    = NUM_STATES;
	localparam int TB    = TOKEN_BITS;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_ADV  = 3'd2;
	localparam logic [2:0] ST_EPS  = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	// beat fields
	logic [STATE_W-1:0]  in_state;
	logic [LABEL_W-1:0]  in_label;
	logic [MASK_W-1:0]   in_mask;
	logic                in_tok_vld;
	logic [TOKEN_W-1:0]  in_token;
	logic [SYMBOL_W-1:0] in_symbol;

	assign in_state   = s_tdata[4:0];
	assign in_label   = s_tdata[13:5];
	assign in_mask    = s_tdata[45:14];
	assign in_tok_vld = s_tdata[46];
	assign in_token   = s_tdata[54:47];
	assign in_symbol  = s_tdata[62:55];

	logic [2:0]          state_q;
	logic [STATE_W-1:0]  start_q;
	logic [AW-1:0]       clr_q;
	logic [CB-1:0]       cnt_q;
	logic [SYMBOL_W-1:0] sym_q;
	logic [NW-1:0]       set_q;
	logic [NW-1:0]       acc_q;     // byte targets gathered during a step
	logic                chg_q;     // closure pass grew the set
	logic                found_q;
	logic [TB-1:0]       best_q;
	logic                rd_vld_s1;
	logic [SB-1:0]       rd_idx_s1;
	logic [NW-1:0]       rdata_s1;

	logic                acc_vld_q [NUM_STATES];
	logic [TB-1:0]       acc_tok_q [NUM_STATES];

	logic [NW-1:0]       tmem [DEPTH];

	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic                in_fire;
	logic                st_ok;
	logic                lab_ok;
	logic                issue;
	logic [SB-1:0]       cnt_idx;
	logic [LABEL_W-1:0]  rd_label;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic                we;
	logic [AW-1:0]       wa;
	logic [NW-1:0]       wd;
	logic                last_ret;
	logic [NW-1:0]       eps_add;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_fire   = s_tvalid && s_tready;
	assign st_ok     = (int'(in_state) < NUM_STATES);
	assign lab_ok    = (int'(in_label) <= EPS_LABEL);
	assign cnt_idx   = cnt_q[SB-1:0];
	assign issue     = ((state_q == ST_ADV) || (state_q == ST_EPS)) &&
	                   (cnt_q != CB'(NUM_STATES));
	assign rd_label  = (state_q == ST_ADV) ? LABEL_W'(sym_q) : LABEL_W'(EPS_LABEL);
	// row = state * 257 + label
	assign rd_addr   = AW'(cnt_idx) * AW'(LABELS) + AW'(rd_label);
	assign wr_addr   = AW'(in_state) * AW'(LABELS) + AW'(in_label);
	assign last_ret  = rd_vld_s1 && (rd_idx_s1 == SB'(NUM_STATES - 1));
	assign eps_add   = set_q[rd_idx_s1] ? (rdata_s1 & ~set_q) : '0;

	always_comb begin
		we = 1'b0;
		wa = wr_addr;
		wd = NW'(in_mask);
		if (state_q == ST_CLR) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (in_fire && (s_tuser == OP_WR_TRANS) && st_ok && lab_ok) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			tmem[wa] <= wd;
		end
		rdata_s1 <= tmem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	// accept entries: small, reset to "no token"
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STATES; i++) begin
				acc_vld_q[i] <= 1'b0;
				acc_tok_q[i] <= '0;
			end
		end else if (in_fire && (s_tuser == OP_WR_ACCEPT) && st_ok) begin
			acc_vld_q[SB'(in_state)] <= in_tok_vld;
			acc_tok_q[SB'(in_state)] <= in_tok_vld ? TB'(in_token) : '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			cnt_q      <= '0;
			sym_q      <= '0;
			set_q      <= '0;
			acc_q      <= '0;
			chg_q      <= 1'b0;
			found_q    <= 1'b0;
			best_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			rd_vld_s1 <= issue;
			rd_idx_s1 <= cnt_idx;
			if (issue) begin
				cnt_q <= cnt_q + CB'(1);
			end
			// in ST_OUT the output register is handled below
			if (m_tvalid_q && m_tready && (state_q != ST_OUT)) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						sym_q   <= in_symbol;
						cnt_q   <= '0;
						chg_q   <= 1'b0;
						found_q <= 1'b0;
						best_q  <= '0;
						case (s_tuser)
							OP_RESTART: begin
								set_q   <= (int'(start_q) < NUM_STATES) ?
								           (NW'(1) << start_q) : '0;
								state_q <= ST_EPS;
							end
							OP_STEP: begin
								acc_q   <= '0;
								state_q <= ST_ADV;
							end
							default: begin
								state_q <= ST_ACC;
							end
						endcase
					end
				end
				ST_ADV: begin
					if (rd_vld_s1 && set_q[rd_idx_s1]) begin
						acc_q <= acc_q | rdata_s1;
					end
					if (last_ret) begin
						set_q   <= (set_q[rd_idx_s1] ? rdata_s1 : '0) | acc_q;
						cnt_q   <= '0;
						chg_q   <= 1'b0;
						state_q <= ST_EPS;
					end
				end
				ST_EPS: begin
					// order of visits does not change the fixpoint
					if (rd_vld_s1) begin
						set_q <= set_q | eps_add;
					end
					if (last_ret) begin
						cnt_q <= '0;
						chg_q <= 1'b0;
						if (!chg_q && (eps_add == '0)) begin
							state_q <= ST_ACC;
						end
					end else if (rd_vld_s1 && (eps_add != '0)) begin
						chg_q <= 1'b1;
					end
				end
				ST_ACC: begin
					if (set_q[cnt_idx] && acc_vld_q[cnt_idx]) begin
						found_q <= 1'b1;
						if (!found_q || (acc_tok_q[cnt_idx] < best_q)) begin
							best_q <= acc_tok_q[cnt_idx];
						end
					end
					cnt_q <= cnt_q + CB'(1);
					if (cnt_q == CB'(NUM_STATES - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {6'd0, 8'(best_q), found_q, (set_q == '0),
						               32'(set_q)};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef ASSERT_OFF
	a_rd_only_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_ADV || state_q == ST_EPS))
		else $error("table read returned outside a walk");

	a_eps_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EPS && $past(state_q) == ST_EPS) |->
		(($past(set_q) & ~set_q) == '0))
		else $error("closure dropped an active state");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result beat without finished item");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV || state_q == ST_EPS || state_q == ST_ACC) |=>
		!$past(in_fire))
		else $error("beat taken while busy");
`endif

endmodule
